FILE: sv/lmsd_pkg.sv
// Shared types and constants for the local maximum strobe detector.
`default_nettype none

package lmsd_pkg;

  localparam int Q_W = 32;
  localparam int CH_W = 8;
  localparam int POS_W = 10;
  localparam int SPOS_W = 11;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SAMPLES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SAMPLES = 8'd1;

  localparam logic [CFG_DATA_W-1:0] DECAY_RESET = 16'd960;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET = 16'd144;

  // Q16.16 reset levels: 10000.0, 5000.0 and 1.0.
  localparam logic signed [Q_W-1:0] OLDER_RESET = 32'sh2710_0000;
  localparam logic signed [Q_W-1:0] MIDDLE_RESET = 32'sh1388_0000;
  localparam logic signed [Q_W-1:0] STEP_RESET = 32'sh0001_0000;

  typedef struct packed {
    logic signed [Q_W-1:0]    older;
    logic signed [Q_W-1:0]    middle;
    logic signed [Q_W-1:0]    newest;
    logic signed [Q_W-1:0]    thr;
    logic signed [Q_W-1:0]    step;
    logic signed [SPOS_W-1:0] last_at;
    logic                     seen;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    older:   OLDER_RESET,
    middle:  MIDDLE_RESET,
    newest:  '0,
    thr:     '0,
    step:    STEP_RESET,
    last_at: '0,
    seen:    1'b0
  };

endpackage

`default_nettype wire

FILE: sv/lmsd_in_if.sv
// Input sample channel: valid/ready handshake with channel, position and sample.
`default_nettype none

interface lmsd_in_if import lmsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       channel;
  logic [POS_W-1:0]      position;
  logic signed [Q_W-1:0] sample;

  modport source (output valid, output channel, output position, output sample,
                  input ready);
  modport sink (input valid, input channel, input position, input sample,
                output ready);
endinterface

`default_nettype wire

FILE: sv/lmsd_out_if.sv
// Result channel: valid/ready handshake with echoed sample and strobe flag.
`default_nettype none

interface lmsd_out_if import lmsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel_out;
  logic signed [Q_W-1:0]    sample_out;
  logic                     strobe_res;
  logic signed [SPOS_W-1:0] strobe_position;

  modport source (output valid, output channel_out, output sample_out,
                  output strobe_res, output strobe_position, input ready);
  modport sink (input valid, input channel_out, input sample_out,
                input strobe_res, input strobe_position, output ready);
endinterface

`default_nettype wire

FILE: sv/lmsd_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface lmsd_cfg_if import lmsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/lmsd_div.sv
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one bit a cycle.
`default_nettype none

module lmsd_div import lmsd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [Q_W-1:0]        dividend,
  input  wire logic [CFG_DATA_W-1:0] divisor,
  output logic                       done,
  output logic [Q_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(Q_W);

  logic                  running;
  logic [CNT_W-1:0]      cnt;
  logic [CFG_DATA_W-1:0] rem;
  logic [CFG_DATA_W-1:0] dvs;
  logic [Q_W-1:0]        qr;
  logic [CFG_DATA_W:0]   shifted;
  logic [CFG_DATA_W:0]   diff;
  logic                  ge;

  // The dividend shifts out of qr at the top while quotient bits enter at the bottom.
  assign shifted = {rem, qr[Q_W-1]};
  assign ge = shifted >= {1'b0, dvs};
  assign diff = shifted - {1'b0, dvs};
  assign quotient = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(Q_W - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      qr <= {qr[Q_W-2:0], ge};
      rem <= ge ? diff[CFG_DATA_W-1:0] : shifted[CFG_DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/lmsd_chan_mem.sv
// Per-channel state memory: one write port, one read port with registered data.
`default_nettype none

module lmsd_chan_mem import lmsd_pkg::*; #(
  parameter int CHANNELS = 256,
  parameter int AW = 8
) (
  input  wire logic        clk,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output chan_state_t      rd_data,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  chan_state_t      wr_data
);

  chan_state_t mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/local_max_strobe_detector.sv
// Local maximum strobe detector: sequencer, config registers and result register.
// A sample passes the read and calculate states to the output state; when the threshold
// rises, a divide state lies between, where the serial divider forms the decay step one
// quotient bit a cycle. An out-of-range channel goes straight to output. The next sample
// is taken only once the result register is loaded, later while backpressure holds it.
// Reset: synchronous; a clearing pass then loads every channel entry.
`default_nettype none

module local_max_strobe_detector import lmsd_pkg::*; #(
  parameter int CHANNELS = 256
) (
  input wire logic    clk,
  input wire logic    rst,
  lmsd_cfg_if.sink    cfg,
  lmsd_in_if.sink     samples,
  lmsd_out_if.source  results
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW = 18;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_CALC  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CFG_DATA_W-1:0] decay_samples;
  logic [CFG_DATA_W-1:0] timeout_samples;

  logic [AW-1:0]         clr_addr;
  logic [AW+CH_W-1:0]    ch_ext;
  logic                  ch_ok;

  logic [CH_W-1:0]       item_channel;
  logic [POS_W-1:0]      item_pos;
  logic signed [Q_W-1:0] item_sample;
  logic [AW-1:0]         item_addr;
  logic                  item_ok;

  chan_state_t           rd_data;
  chan_state_t           wr_data;
  chan_state_t           upd;
  chan_state_t           calc;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;

  logic                  res_strobe;
  logic signed [SPOS_W-1:0] res_pos;

  logic                  seen0;
  logic                  rise;
  logic                  peak;
  logic                  strobe;
  logic signed [SPOS_W-1:0] at;
  logic signed [TW-1:0]  gap;
  logic signed [Q_W-1:0] thr_final;

  logic                  div_start;
  logic                  div_done;
  logic [Q_W-1:0]        quotient;
  logic [CFG_DATA_W-1:0] divisor;

  logic                  out_valid;
  logic [CH_W-1:0]       out_channel;
  logic signed [Q_W-1:0] out_sample;
  logic                  out_strobe;
  logic signed [SPOS_W-1:0] out_pos;
  logic                  out_go;
  logic                  in_beat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_samples <= DECAY_RESET;
      timeout_samples <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_DECAY_SAMPLES) begin
        decay_samples <= cfg.data;
      end else if (cfg.index == REG_TIMEOUT_SAMPLES) begin
        timeout_samples <= cfg.data;
      end
    end
  end

  assign ch_ext = (AW + CH_W)'(samples.channel);
  assign ch_ok = ch_ext < (AW + CH_W)'(CHANNELS);
  assign samples.ready = (state == ST_IDLE);
  assign in_beat = samples.valid && samples.ready;
  assign out_go = (state == ST_OUT) && (!out_valid || results.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(CHANNELS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_beat) state_next = ch_ok ? ST_READ : ST_OUT;
      ST_READ:  state_next = ST_CALC;
      ST_CALC:  state_next = rise ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:   if (out_go) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_channel <= samples.channel;
      item_pos <= samples.position;
      item_sample <= samples.sample;
      item_addr <= ch_ext[AW-1:0];
      item_ok <= ch_ok;
    end
  end

  lmsd_chan_mem #(
    .CHANNELS(CHANNELS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .rd_en(state == ST_READ),
    .rd_addr(item_addr),
    .rd_data(rd_data),
    .wr_en(mem_we),
    .wr_addr(mem_waddr),
    .wr_data(wr_data)
  );

  // Window shift, threshold rise test and strobe decision, from the read-back entry.
  always_comb begin
    seen0 = (item_pos == '0) ? 1'b0 : rd_data.seen;
    at = $signed({1'b0, item_pos}) - 11'sd1;
    gap = TW'(at) - TW'(rd_data.last_at);
    rise = $signed(rd_data.newest) >= $signed(rd_data.thr);
    peak = ($signed(rd_data.middle) < $signed(rd_data.newest)) &&
           ($signed(item_sample) < $signed(rd_data.newest));
    strobe = rise && peak &&
             (!seen0 || (gap > $signed({2'b00, timeout_samples})));
    calc.older = rd_data.middle;
    calc.middle = rd_data.newest;
    calc.newest = item_sample;
    calc.thr = rise ? rd_data.newest : rd_data.thr;
    calc.step = rd_data.step;
    calc.last_at = strobe ? at : rd_data.last_at;
    calc.seen = seen0 || strobe;
  end

  assign divisor = (decay_samples == '0) ? CFG_DATA_W'(1) : decay_samples;
  assign div_start = (state == ST_CALC) && rise;

  lmsd_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(rd_data.newest),
    .divisor(divisor),
    .done(div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_strobe <= 1'b0;
      res_pos <= '0;
    end else if (state == ST_CALC) begin
      upd <= calc;
      res_strobe <= strobe;
      res_pos <= strobe ? at : '0;
    end else if ((state == ST_DIV) && div_done) begin
      upd.step <= quotient;
    end
  end

  // Linear decay after the sample, clamped at zero.
  assign thr_final = ($signed(upd.thr) > $signed(upd.step)) ? (upd.thr - upd.step) : '0;

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_data = CHAN_RESET;
      mem_waddr = clr_addr;
      mem_we = 1'b1;
    end else begin
      wr_data = upd;
      wr_data.thr = thr_final;
      mem_waddr = item_addr;
      mem_we = out_go && item_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_go) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      out_channel <= item_channel;
      out_sample <= item_sample;
      out_strobe <= res_strobe;
      out_pos <= res_pos;
    end
  end

  assign results.valid = out_valid;
  assign results.channel_out = out_channel;
  assign results.sample_out = out_sample;
  assign results.strobe_res = out_strobe;
  assign results.strobe_position = out_pos;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !samples.ready)
    else $error("sample taken during the clearing pass");

  a_thr_nonneg: assert property (@(posedge clk) disable iff (rst)
    mem_we && state == ST_OUT |-> !wr_data.thr[Q_W-1])
    else $error("negative threshold written back");

  a_pos_zero_no_strobe: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.strobe_res |-> results.strobe_position == '0)
    else $error("strobe position set on a beat without a strobe");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the local maximum strobe detector.
module testbench;
  import lmsd_pkg::*;

  typedef struct {
    logic [CH_W-1:0]       channel;
    logic [POS_W-1:0]      position;
    logic signed [Q_W-1:0] sample;
  } sample_beat_t;

  typedef struct {
    logic [CH_W-1:0]          channel;
    logic signed [Q_W-1:0]    sample;
    logic                     strobe;
    logic signed [SPOS_W-1:0] spos;
  } strobe_beat_t;

  localparam int N_CH = 256;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [CFG_DATA_W-1:0] DECAY_SET [N_PHASES] =
    '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd960, 16'd300};
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_SET [N_PHASES] =
    '{16'd0, 16'd65535, 16'd3, 16'd144, 16'd20, 16'd1};

  logic clk;
  logic rst;

  lmsd_cfg_if cfg_ch ();
  lmsd_in_if in_ch ();
  lmsd_out_if out_ch ();

  local_max_strobe_detector u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .samples(in_ch),
    .results(out_ch)
  );

  // Predictor state, one entry per channel.
  logic signed [Q_W-1:0] win_old [N_CH];
  logic signed [Q_W-1:0] win_mid [N_CH];
  logic signed [Q_W-1:0] win_new [N_CH];
  logic signed [Q_W-1:0] thr_level [N_CH];
  logic signed [Q_W-1:0] thr_step [N_CH];
  int                    last_hit [N_CH];
  bit                    hit_seen [N_CH];
  logic [CFG_DATA_W-1:0] cfg_decay;
  logic [CFG_DATA_W-1:0] cfg_timeout;

  sample_beat_t sample_q [$];
  strobe_beat_t strobe_expect_q [$];
  sample_beat_t cur_beat;

  bit in_taken;
  bit no_idle;
  bit hold_done;
  int gap_left;
  int stall_left;
  int results_seen;
  int fails;

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [Q_W-1:0] q16(int v);
    return v <<< 16;
  endfunction

  function automatic strobe_beat_t detect_strobe(sample_beat_t b);
    strobe_beat_t r;
    int c;
    int at;
    logic [Q_W-1:0] div;
    logic signed [Q_W-1:0] mid;
    r.channel = b.channel;
    r.sample = b.sample;
    r.strobe = 1'b0;
    r.spos = '0;
    c = int'(b.channel);
    at = int'(b.position) - 1;
    if (c < N_CH) begin
      if (b.position == '0) hit_seen[c] = 1'b0;
      win_old[c] = win_mid[c];
      win_mid[c] = win_new[c];
      win_new[c] = b.sample;
      mid = win_mid[c];
      if (mid >= thr_level[c]) begin
        div = (cfg_decay == '0) ? 32'd1 : {16'd0, cfg_decay};
        thr_level[c] = mid;
        thr_step[c] = $signed($unsigned(mid) / div);
        if (win_old[c] < mid && win_new[c] < mid &&
            (!hit_seen[c] || (at - last_hit[c]) > int'(cfg_timeout))) begin
          hit_seen[c] = 1'b1;
          last_hit[c] = at;
          r.strobe = 1'b1;
          r.spos = SPOS_W'(at);
        end
      end
      thr_level[c] = (thr_level[c] > thr_step[c]) ? thr_level[c] - thr_step[c] : '0;
    end
    return r;
  endfunction

  task automatic push_item(int ch, int pos, logic signed [Q_W-1:0] s);
    sample_beat_t b;
    b.channel = CH_W'(ch);
    b.position = POS_W'(pos);
    b.sample = s;
    sample_q.push_back(b);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DECAY_SAMPLES: cfg_decay = val;
      REG_TIMEOUT_SAMPLES: cfg_timeout = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers may only change once the block has drained.
  task automatic wait_idle();
    while (sample_q.size() != 0 || strobe_expect_q.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Sample driver.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      strobe_expect_q.push_back(detect_strobe(cur_beat));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() > 0) begin
        cur_beat = sample_q.pop_front();
        in_ch.channel <= cur_beat.channel;
        in_ch.position <= cur_beat.position;
        in_ch.sample <= cur_beat.sample;
        in_ch.valid <= 1'b1;
        gap_left <= no_idle ? 0 : idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure, with one long hold-off so the input side stalls.
  always @(negedge clk) begin
    int n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!hold_done && results_seen >= 250) begin
      out_ch.ready <= 1'b0;
      stall_left <= 400;
      hold_done <= 1'b1;
    end else if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      n = idle_len();
      out_ch.ready <= (n == 0);
      stall_left <= n;
    end
  end

  // Result monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    strobe_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (strobe_expect_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: ch %0d sample %h strobe %b pos %0d",
                   out_ch.channel_out, out_ch.sample_out, out_ch.strobe_res,
                   out_ch.strobe_position);
      end else begin
        want = strobe_expect_q.pop_front();
        if (out_ch.channel_out !== want.channel || out_ch.sample_out !== want.sample ||
            out_ch.strobe_res !== want.strobe || out_ch.strobe_position !== want.spos) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected ch %0d sample %h strobe %b pos %0d, got ch %0d sample %h strobe %b pos %0d",
                     want.channel, want.sample, want.strobe, want.spos,
                     out_ch.channel_out, out_ch.sample_out, out_ch.strobe_res,
                     out_ch.strobe_position);
        end
      end
    end
  end

  initial begin
    int p;
    int k;
    int i;
    int r;
    int ch;
    int pos;
    int chan_set [4];
    int pos_next [N_CH];
    logic signed [Q_W-1:0] s;
    logic signed [Q_W-1:0] last_s [N_CH];

    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.channel = '0;
    in_ch.position = '0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_decay = DECAY_RESET;
    cfg_timeout = TIMEOUT_RESET;
    for (i = 0; i < N_CH; i++) begin
      win_old[i] = OLDER_RESET;
      win_mid[i] = MIDDLE_RESET;
      win_new[i] = '0;
      thr_level[i] = '0;
      thr_step[i] = STEP_RESET;
      last_hit[i] = 0;
      hit_seen[i] = 1'b0;
      pos_next[i] = 0;
      last_s[i] = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Strobe, then a peak inside the timeout that must be dropped.
    push_item(1, 10, q16(100));
    push_item(1, 11, q16(500));
    push_item(1, 12, q16(50));
    push_item(1, 13, q16(600));
    push_item(1, 14, q16(10));
    // Peak on the last sample of a frame lands at -1 and counts for the new frame.
    push_item(1, 1023, q16(700));
    push_item(1, 0, q16(20));
    push_item(1, 1, q16(900));
    push_item(1, 2, q16(30));
    // Full-scale samples.
    push_item(0, 0, 32'sh7FFF_FFFF);
    push_item(0, 1, 32'sh8000_0000);
    push_item(0, 2, '0);
    push_item(255, 1023, -32'sd1);
    push_item(255, 1022, q16(-5000));
    push_item(170, 682, 32'sh5555_5555);
    push_item(85, 341, 32'shAAAA_AAAA);
    // A flat top is not a strict peak.
    push_item(2, 5, q16(1));
    push_item(2, 6, q16(300));
    push_item(2, 7, q16(300));
    push_item(2, 8, q16(1));
    wait_idle();

    for (p = 0; p < N_PHASES; p++) begin
      write_reg(REG_DECAY_SAMPLES, DECAY_SET[p]);
      write_reg(REG_TIMEOUT_SAMPLES, TIMEOUT_SET[p]);
      if (p == 3) write_reg(REG_UNMAPPED, 16'hFFFF);
      no_idle = (p == 2);
      for (i = 0; i < 4; i++) begin
        chan_set[i] = $urandom_range(0, N_CH - 1);
        pos_next[chan_set[i]] = $urandom_range(960, 1023);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          // Well-formed per-channel sequence: positions mostly advance by one.
          ch = chan_set[$urandom_range(0, 3)];
          pos = pos_next[ch];
          r = $urandom_range(0, 99);
          if (r < 3) pos_next[ch] = 0;
          else if (r < 7) pos_next[ch] = (pos + $urandom_range(2, 8)) % 1024;
          else pos_next[ch] = (pos + 1) % 1024;
          r = $urandom_range(0, 99);
          if (r < 70) s = int'($urandom_range(0, 2000 * 65536)) - 100 * 65536;
          else if (r < 82) s = $urandom();
          else if (r < 92) s = last_s[ch];
          else begin
            case ($urandom_range(0, 2))
              0: s = 32'sh7FFF_FFFF;
              1: s = 32'sh8000_0000;
              default: s = '0;
            endcase
          end
        end else begin
          ch = $urandom_range(0, N_CH - 1);
          pos = $urandom_range(0, 1023);
          s = $urandom();
        end
        last_s[ch] = s;
        push_item(ch, pos, s);
      end
      wait_idle();
    end

    if (fails == 0 && strobe_expect_q.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
